FILE: src/cfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfm_pkg
// Shared types and constants for the clock frequency monitor: function codes,
// field widths, register bit positions and the transaction payload.
// ============================================================================
package cfm_pkg;

    // Number of clock sources that can be selected. The selector field is
    // five bits wide whatever this value is.
    localparam int unsigned NUM_SOURCES = 32;

    localparam int unsigned SEL_W  = 5;
    localparam int unsigned REF_W  = 9;
    localparam int unsigned EDGE_W = 14;

    // Bit positions in the written word and in the packed register.
    localparam int unsigned SEL_LSB   = 24;
    localparam int unsigned START_BIT = 23;

    localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] write_data;
        logic        ref_tick;
        logic [31:0] source_edges;
    } t_item;

endpackage
`default_nettype wire

FILE: src/clock_frequency_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// clock_frequency_monitor
// Reference-gated frequency counter register. Each input transaction is a
// register write, a register read or a clock tick; every transaction returns
// exactly one result holding the packed register as it stands afterwards.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries i_func,
// i_write_data, i_ref_tick and i_source_edges. The output channel
// (o_out_valid / i_out_ready) carries o_read_data and o_measuring. A write
// with bit 23 set starts a measurement; tick transactions then count edges
// of the selected source until the reference count runs out or the edge
// count saturates.
// Pipeline: an accepted transaction is held in the input register, and its
// result is loaded into the output register when cfm_core takes it from
// there. Throughput is one transaction per cycle while the receiver does
// not stall; the state update in cfm_core is combinational.
// Reset clears the selector, both counts, the running flag and both valid
// flags. When the receiver stalls, the result waits in the output register
// while one more transaction can still be taken into the input register;
// o_in_ready drops only when both registers are full.
// ============================================================================
module clock_frequency_monitor
    import cfm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_write_data,
    input  wire logic        i_ref_tick,
    input  wire logic [31:0] i_source_edges,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_read_data,
    output logic             o_measuring
);

    t_item in_item;
    t_item stage_item;
    logic  stage_valid;
    logic  advance;

    assign in_item = '{func:         i_func,
                       write_data:   i_write_data,
                       ref_tick:     i_ref_tick,
                       source_edges: i_source_edges};

    // Input register stage.
    cfm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    // Register state, update logic and output register.
    cfm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (stage_valid),
        .i_item       (stage_item),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_measuring  (o_measuring)
    );

    // A running measurement always has reference ticks left.
    a_run_has_ref : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_measuring) |-> (o_read_data[REF_W-1:0] != '0))
        else $error("measurement running with zero reference count");

    // A running measurement never sits at edge saturation.
    a_run_below_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_measuring) |-> (o_read_data[START_BIT-1:REF_W] != EDGE_MAX))
        else $error("measurement running at saturated edge count");

    // The status flag and the running bit of the packed register agree.
    a_flag_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_measuring == o_read_data[START_BIT]))
        else $error("measuring flag disagrees with packed register");

    // With both stages full and the receiver stalled, nothing more is taken.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transaction accepted while both stages are full");

endmodule
`default_nettype wire

FILE: src/cfm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfm_in_stage
// Input register: captures one transaction and holds it until the result
// stage takes it.
// ============================================================================
module cfm_in_stage
    import cfm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_item_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register frees up whenever its content moves on.
    assign o_in_ready   = !r_valid || i_advance;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: src/cfm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfm_core
// Monitor register state, its update for one transaction, and the result
// register that presents the packed register after that transaction.
// ============================================================================
module cfm_core
    import cfm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_advance,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [31:0] o_read_data,
    output logic       o_measuring
);

    logic [SEL_W-1:0]  r_sel;
    logic              r_run;
    logic [REF_W-1:0]  r_ref;
    logic [EDGE_W-1:0] r_edge;
    logic [SEL_W-1:0]  n_sel;
    logic              n_run;
    logic [REF_W-1:0]  n_ref;
    logic [EDGE_W-1:0] n_edge;

    logic              r_out_valid;
    logic [31:0]       r_read_data;
    logic              r_measuring;

    logic              sel_in_range;
    logic              edge_seen;
    logic              fire;

    assign o_advance   = !r_out_valid || i_out_ready;
    assign fire        = i_item_valid && o_advance;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_measuring = r_measuring;

    assign sel_in_range = ({1'b0, r_sel} < (SEL_W + 1)'(NUM_SOURCES));
    assign edge_seen    = sel_in_range && i_item.source_edges[r_sel];

    always_comb begin
        n_sel  = r_sel;
        n_run  = r_run;
        n_ref  = r_ref;
        n_edge = r_edge;
        case (i_item.func)
            FUNC_WRITE: begin
                n_sel = i_item.write_data[SEL_LSB +: SEL_W];
                if (i_item.write_data[START_BIT]) begin
                    n_ref  = i_item.write_data[REF_W-1:0];
                    n_edge = '0;
                    n_run  = (i_item.write_data[REF_W-1:0] != '0);
                end else begin
                    n_run = 1'b0;
                end
            end
            FUNC_TICK: begin
                if (r_run) begin
                    // Edge first, then the reference tick, then the stop test.
                    if (edge_seen && (r_edge != EDGE_MAX)) begin
                        n_edge = r_edge + 1'b1;
                    end
                    if (i_item.ref_tick && (r_ref != '0)) begin
                        n_ref = r_ref - 1'b1;
                    end
                    if ((n_ref == '0) || (n_edge == EDGE_MAX)) begin
                        n_run = 1'b0;
                    end
                end
            end
            default: begin
                // Reads and the unused code leave the state alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= '0;
            r_run       <= 1'b0;
            r_ref       <= '0;
            r_edge      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_sel  <= n_sel;
                r_run  <= n_run;
                r_ref  <= n_ref;
                r_edge <= n_edge;
            end
            if (o_advance) begin
                r_out_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data <= {3'b000, n_sel, n_run, n_edge, n_ref};
            r_measuring <= n_run;
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for clock_frequency_monitor. A register image kept
// in the bench follows every accepted transaction and predicts the packed
// register and the measuring flag that the block must return. Directed cases
// cover writes, starts, window ends, restarts and edge saturation. Random
// measurement sequences follow, with idling and stalls on both channels.
// ============================================================================
module tb;
    import cfm_pkg::*;

    // The fourth function code is not used by the block and must act as a read.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SETTLE_CYCLES = 8;

    // One returned transaction: the packed register and the running flag.
    typedef struct packed {
        logic [31:0] word;
        logic        busy;
    } t_readback;

    // Clock, reset and block ports. Every input has a known value from time zero.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_func         = FUNC_READ;
    logic [31:0] i_write_data   = '0;
    logic        i_ref_tick     = 1'b0;
    logic [31:0] i_source_edges = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_read_data;
    logic        o_measuring;

    // Idling on both channels can be switched off for a stretch of the run.
    logic idle_enable = 1'b1;

    // Receiver hold-off: the stimulus bumps hold_req and the receiver process
    // then counts out the hold on its own.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    // Register image used to predict every result.
    logic [SEL_W-1:0]  sel_img      = '0;
    logic              run_img      = 1'b0;
    logic [REF_W-1:0]  ref_left_img = '0;
    logic [EDGE_W-1:0] edge_cnt_img = '0;

    t_readback expected_readback[$];

    int failures      = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int starts_seen   = 0;
    int windows_ended = 0;
    int saturations   = 0;

    clock_frequency_monitor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_write_data   (i_write_data),
        .i_ref_tick     (i_ref_tick),
        .i_source_edges (i_source_edges),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_measuring    (o_measuring)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction. The image is updated in the order in which transactions are
    // accepted, which is also the order in which their results must come out.
    // ------------------------------------------------------------------------
    task automatic update_register_image(input logic [1:0] func, input logic [31:0] wdata,
                                         input logic tick, input logic [31:0] edges);
        logic      seen;
        t_readback outcome;
        case (func)
            FUNC_WRITE: begin
                sel_img = wdata[SEL_LSB +: SEL_W];
                if (wdata[START_BIT]) begin
                    // A start reloads the window and clears the edge count. A
                    // zero window never gets going.
                    ref_left_img = wdata[REF_W-1:0];
                    edge_cnt_img = '0;
                    run_img      = (wdata[REF_W-1:0] != '0);
                    starts_seen++;
                end else begin
                    // A plain write only moves the selector and halts any run.
                    run_img = 1'b0;
                end
            end
            FUNC_TICK: begin
                if (run_img) begin
                    // The edge is counted first, then the reference tick is
                    // taken, and only then is the stop condition tested.
                    seen = (sel_img < NUM_SOURCES) && edges[sel_img];
                    if (seen && edge_cnt_img != EDGE_MAX)
                        edge_cnt_img = edge_cnt_img + 1'b1;
                    if (tick && ref_left_img != '0)
                        ref_left_img = ref_left_img - 1'b1;
                    if (ref_left_img == '0 || edge_cnt_img == EDGE_MAX) begin
                        run_img = 1'b0;
                        if (edge_cnt_img == EDGE_MAX)
                            saturations++;
                        else
                            windows_ended++;
                    end
                end
            end
            default: ;
        endcase
        outcome.word = {3'b000, sel_img, run_img, edge_cnt_img, ref_left_img};
        outcome.busy = run_img;
        expected_readback.push_back(outcome);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Valid is left high after acceptance so that back-to-back
    // transactions follow without a bubble; every test ends with a drain,
    // which lowers it.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] func, input logic [31:0] wdata,
                             input logic tick, input logic [31:0] edges);
        if (idle_enable && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_write_data   <= wdata;
        i_ref_tick     <= tick;
        i_source_edges <= edges;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        items_sent++;
        update_register_image(func, wdata, tick, edges);
    endtask

    // The sender stops and waits until every expected result has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_readback.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_readback.size() != 0) begin
            $error("%0d results still outstanding after %0d cycles",
                   expected_readback.size(), waited);
            failures++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds a written word with the given fields and random bits elsewhere,
    // so that the ignored bits of write_data are exercised too.
    function automatic logic [31:0] control_word(input logic [SEL_W-1:0] sel,
                                                 input logic start,
                                                 input logic [REF_W-1:0] window);
        logic [31:0] word;
        word = $urandom;
        word[SEL_LSB +: SEL_W] = sel;
        word[START_BIT]        = start;
        word[REF_W-1:0]        = window;
        return word;
    endfunction

    // A tick with the selected source's edge forced to the given value.
    task automatic send_tick(input logic tick, input logic [SEL_W-1:0] sel, input logic hit);
        logic [31:0] edges;
        edges      = $urandom;
        edges[sel] = hit;
        send_item(FUNC_TICK, $urandom, tick, edges);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when one is requested.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_enable && ($urandom_range(99) < 8));
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result is compared with the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_result
        t_readback want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readback.size() == 0) begin
                $error("result with no transaction outstanding: read_data %h measuring %b",
                       o_read_data, o_measuring);
                failures++;
            end else begin
                want = expected_readback.pop_front();
                results_seen++;
                if (o_read_data !== want.word) begin
                    $error("read_data: expected %h, actual %h", want.word, o_read_data);
                    failures++;
                end
                if (o_measuring !== want.busy) begin
                    $error("measuring: expected %b, actual %b", want.busy, o_measuring);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // After reset the register reads as zero; the spare code reads the same.
    task automatic test_reset_state();
        send_item(FUNC_READ, $urandom, 1'b1, $urandom);
        send_item(FUNC_SPARE, $urandom, 1'b1, 32'hFFFF_FFFF);
        send_tick(1'b1, 5'd0, 1'b1);
        drain_results();
    endtask

    // Writes with and without start, a zero window, and a halt mid-run.
    task automatic test_write_paths();
        send_item(FUNC_WRITE, 32'hFF7F_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(FUNC_READ, 32'h0000_0000, 1'b0, 32'h0000_0000);
        send_item(FUNC_WRITE, control_word(5'd9, 1'b1, 9'd0), 1'b0, '0);
        send_tick(1'b1, 5'd9, 1'b1);
        send_item(FUNC_WRITE, 32'hFFFF_FFFF, 1'b0, '0);
        send_item(FUNC_TICK, '0, 1'b1, 32'hFFFF_FFFF);
        send_item(FUNC_TICK, '0, 1'b0, 32'h7FFF_FFFF);
        send_item(FUNC_WRITE, control_word(5'd31, 1'b0, 9'd0), 1'b1, '0);
        send_item(FUNC_TICK, '0, 1'b1, 32'hFFFF_FFFF);
        send_item(FUNC_SPARE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // A short window runs out; then a restart while running clears the count.
    task automatic test_window_end();
        send_item(FUNC_WRITE, control_word(5'd0, 1'b1, 9'd3), 1'b0, '0);
        send_item(FUNC_TICK, '0, 1'b1, 32'h0000_0001);
        send_item(FUNC_TICK, '0, 1'b0, 32'hFFFF_FFFE);
        send_item(FUNC_TICK, '0, 1'b1, 32'h0000_0001);
        send_item(FUNC_TICK, '0, 1'b1, 32'h0000_0001);
        send_item(FUNC_TICK, '0, 1'b1, 32'h0000_0001);
        send_item(FUNC_WRITE, control_word(5'd5, 1'b1, 9'd2), 1'b0, '0);
        send_tick(1'b0, 5'd5, 1'b1);
        send_item(FUNC_WRITE, control_word(5'd6, 1'b1, 9'd1), 1'b0, '0);
        send_tick(1'b1, 5'd6, 1'b1);
        send_item(FUNC_READ, '0, 1'b0, '0);
        drain_results();
    endtask

    // The edge count climbs all the way to its ceiling inside a long window
    // and the run stops there; a further tick changes nothing.
    task automatic test_edge_saturation();
        send_item(FUNC_WRITE, control_word(5'd17, 1'b1, 9'd511), 1'b0, '0);
        for (int n = 0; n < int'(EDGE_MAX) + 2; n++)
            send_tick(1'b0, 5'd17, 1'b1);
        send_item(FUNC_READ, '0, 1'b0, '0);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while transactions keep being
    // offered, so the block fills up and stalls its input.
    task automatic test_backpressure();
        idle_enable <= 1'b0;
        hold_req    <= hold_req + 1;
        send_item(FUNC_WRITE, control_word(5'($urandom), 1'b1, 9'd20), 1'b0, '0);
        for (int n = 0; n < 40; n++)
            send_tick(1'($urandom), sel_img, 1'($urandom));
        idle_enable <= 1'b1;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Random test: mostly complete measurements with random content, with
    // reads, halts, spare codes and plain noise mixed in.
    // ------------------------------------------------------------------------
    task automatic test_random_measurements();
        int               sent;
        int               ticks;
        int               pick;
        logic [SEL_W-1:0] sel;
        logic [REF_W-1:0] window;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // A long stretch in the middle runs with no idling on either side.
            idle_enable <= !(sent >= 600 && sent < 1000);
            if (sent >= 1200 && sent < 1260 && hold_req == hold_ack)
                hold_req <= hold_req + 1;
            pick = $urandom_range(99);
            if (pick < 85) begin
                sel    = 5'($urandom);
                pick   = $urandom_range(99);
                window = (pick < 3)  ? 9'd0 :
                         (pick < 6)  ? 9'($urandom_range(511, 100)) :
                         9'($urandom_range(24, 1));
                send_item(FUNC_WRITE, control_word(sel, 1'b1, window), 1'($urandom),
                          $urandom);
                sent++;
                ticks = int'(window) + $urandom_range(int'(window) + 4);
                for (int n = 0; n < ticks && sent < RANDOM_ITEMS; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        send_item(FUNC_READ, $urandom, 1'($urandom), $urandom);
                    else if (pick < 10)
                        send_item(FUNC_SPARE, $urandom, 1'($urandom), $urandom);
                    else if (pick < 11)
                        send_item(FUNC_WRITE,
                                  control_word(5'($urandom), 1'b0, 9'($urandom)),
                                  1'($urandom), $urandom);
                    else
                        send_tick($urandom_range(99) < 60, sel_img, 1'($urandom));
                    sent++;
                end
            end else begin
                send_item(2'($urandom), $urandom, 1'($urandom), $urandom);
                sent++;
            end
            // Now and then the sender pauses until everything has come back.
            if ($urandom_range(99) < 2)
                drain_results();
        end
        idle_enable <= 1'b1;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests and the final verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_write_paths();
        test_window_end();
        test_edge_saturation();
        test_backpressure();
        test_random_measurements();

        if (expected_readback.size() != 0) begin
            $error("%0d expected results never arrived", expected_readback.size());
            failures++;
        end
        $display("Sent %0d transactions and checked %0d results, %0d failures.",
                 items_sent, results_seen, failures);
        $display("Measurements started: %0d; windows run out: %0d; edge saturations: %0d.",
                 starts_seen, windows_ended, saturations);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/cfm_pkg.sv
src/cfm_in_stage.sv
src/cfm_core.sv
src/clock_frequency_monitor.sv
tb/tb.sv
